[rtl/tmps_pkg.sv]
`default_nettype none
package tmps_pkg;
  localparam int SamplesPerReading = 5;
  localparam int HistoryLag = 3;
  localparam int SampleBits = 12;
  localparam int HistDepth = HistoryLag + 1;
  localparam int CntBits = $clog2(SamplesPerReading + 1);
  localparam int IdxBits = (SamplesPerReading > 1) ? $clog2(SamplesPerReading) : 1;
  localparam int SumBits = SampleBits + $clog2(SamplesPerReading);
  localparam int QuotBits = 15;
  localparam int DivBits = SampleBits + 1 + 14;
  localparam int DivCntBits = $clog2(QuotBits + 1);
  localparam int AvgShift = SumBits + 3;
  localparam int AvgRecip = (2**AvgShift + SamplesPerReading - 3) / (SamplesPerReading - 2);
  localparam int TenShift = SampleBits + 7;
  localparam int TenRecip = (2**TenShift + 9) / 10;
  localparam logic signed [15:0] OneQ14 = 16'sd16384;
  localparam logic signed [18:0] RateLimit = 19'sd11469;

  localparam logic [0:0] RegPGain = 1'b0;
  localparam logic [0:0] RegDGain = 1'b1;

  typedef enum logic [2:0] {
    ST_COLLECT, ST_SORT, ST_TRIM, ST_DIVIDE, ST_RATE, ST_MUL, ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic done;
  } lane_ctl_t;
endpackage
`default_nettype wire

[rtl/tmps_lane.sv]
`default_nettype none
module tmps_lane
  import tmps_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   wr,
  input  wire [IdxBits-1:0]     wr_idx,
  input  wire [SampleBits-1:0]  wr_data,
  input  wire                   start,
  output logic [SampleBits-1:0] trimmed,
  output logic                  done
);
  logic [SampleBits-1:0] buffer [SamplesPerReading];
  logic [IdxBits-1:0] pass;
  logic busy;
  logic phase;
  logic [SumBits-1:0] sum;
  logic [SumBits+AvgShift:0] avg_prod;
  logic [SampleBits-1:0] avg_q;
  logic [SampleBits+TenShift-1:0] tens_prod;
  logic [SampleBits-1:0] tens;
  logic [SampleBits-1:0] flo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      pass <= '0;
      phase <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        pass <= '0;
        phase <= 1'b0;
      end else if (busy) begin
        phase <= ~phase;
        if (phase) begin
          if (pass == IdxBits'(SamplesPerReading - 1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            pass <= pass + 1'b1;
          end
        end
      end
    end
    if (wr) begin
      buffer[wr_idx] <= wr_data;
    end else if (busy) begin
      for (int i = 0; i + 1 < SamplesPerReading; i++) begin
        if ((i % 2) == (phase ? 1 : 0) && buffer[i] > buffer[i+1]) begin
          buffer[i] <= buffer[i+1];
          buffer[i+1] <= buffer[i];
        end
      end
    end
    avg_q <= avg_prod[AvgShift +: SampleBits];
  end

  always_comb begin
    sum = '0;
    for (int i = 1; i < SamplesPerReading - 1; i++) begin
      sum = sum + SumBits'(buffer[i]);
    end
    avg_prod = (SumBits+AvgShift+1)'(sum) * (SumBits+AvgShift+1)'(AvgRecip);
    tens_prod = (SampleBits+TenShift)'(avg_q) * (SampleBits+TenShift)'(TenRecip);
    tens = tens_prod[TenShift +: SampleBits];
    flo = SampleBits'({tens, 3'b000} + {tens, 1'b0});
  end

  assign trimmed = flo;
endmodule
`default_nettype wire

[rtl/tmps_div.sv]
`default_nettype none
module tmps_div
  import tmps_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   start,
  input  wire [DivBits-1:0]     dividend,
  input  wire [SampleBits:0]    divisor,
  output logic [QuotBits-1:0]   quotient,
  output logic                  done
);
  logic [DivBits-1:0] rem;
  logic [DivBits-1:0] num;
  logic [SampleBits:0] den;
  logic [DivCntBits-1:0] cnt;
  logic busy;
  logic [DivBits-1:0] trial;

  assign trial = {rem[DivBits-2:0], num[QuotBits-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        rem <= DivBits'(dividend >> QuotBits);
        num <= dividend;
        den <= divisor;
        quotient <= '0;
      end else if (busy) begin
        num <= num << 1;
        if (trial >= DivBits'(den)) begin
          rem <= trial - DivBits'(den);
          quotient <= {quotient[QuotBits-2:0], 1'b1};
        end else begin
          rem <= trial;
          quotient <= {quotient[QuotBits-2:0], 1'b0};
        end
        if (cnt == DivCntBits'(QuotBits - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

[rtl/trimmed_mean_pd_steering_unit.sv]
// Throughput: one pair per cycle for the first four pairs of a reading; the last pair
//   drops s_tready until the result is loaded for output (ten sort phases, the 15-step
//   divider, PD arithmetic); a result held by m_tready stalls it further.
// Reset: synchronous, clears count, history and handshakes; gains to 1000 and 0.
`default_nettype none
module trimmed_mean_pd_steering_unit
  import tmps_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire [23:0] s_tdata,   // left_sample[11:0], right_sample[23:12]
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [47:0] m_tdata,  // steer_drive[15:0], position_error[31:16], error_rate[46:32]
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire        cfg_index,
  input  wire [15:0] cfg_data
);
  state_t state, state_next;
  logic [CntBits-1:0] count;
  logic [15:0] p_gain, d_gain;
  logic signed [15:0] hist [HistDepth];
  logic [SampleBits-1:0] l_val, r_val;
  lane_ctl_t l_ctl, r_ctl;
  logic l_done, r_done, got_l, got_r;
  logic div_start, div_done;
  logic [QuotBits-1:0] quot;
  logic neg, zero_sum;
  logic signed [15:0] err;
  logic signed [14:0] rate;
  logic signed [33:0] prod_p, prod_d;
  logic signed [35:0] acc;
  logic signed [35:0] mag;
  logic signed [35:0] drive;
  logic [15:0] drive_q;
  logic signed [18:0] rate_raw;
  logic [SampleBits:0] lsum;
  logic [SampleBits-1:0] ldiff;
  logic accept;

  assign s_tready = (state == ST_COLLECT);
  assign cfg_ready = 1'b1;
  assign accept = s_tvalid && s_tready;
  assign l_ctl.start = accept && (count == CntBits'(SamplesPerReading - 1));
  assign r_ctl.start = l_ctl.start;
  assign l_ctl.done = l_done;
  assign r_ctl.done = r_done;

  tmps_lane u_left (
    .clk(clk), .rst(rst), .wr(accept), .wr_idx(count[IdxBits-1:0]),
    .wr_data(s_tdata[SampleBits-1:0]), .start(l_ctl.start),
    .trimmed(l_val), .done(l_done)
  );
  tmps_lane u_right (
    .clk(clk), .rst(rst), .wr(accept), .wr_idx(count[IdxBits-1:0]),
    .wr_data(s_tdata[12 +: SampleBits]), .start(r_ctl.start),
    .trimmed(r_val), .done(r_done)
  );

  assign lsum = {1'b0, l_val} + {1'b0, r_val};
  assign ldiff = (l_val >= r_val) ? (l_val - r_val) : (r_val - l_val);
  assign div_start = (state == ST_TRIM);

  tmps_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend({1'b0, ldiff, 14'd0}), .divisor(lsum),
    .quotient(quot), .done(div_done)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_COLLECT: if (l_ctl.start) state_next = ST_SORT;
      ST_SORT:    if ((got_l || l_ctl.done) && (got_r || r_ctl.done)) state_next = ST_TRIM;
      ST_TRIM:    state_next = ST_DIVIDE;
      ST_DIVIDE:  if (div_done) state_next = ST_RATE;
      ST_RATE:    state_next = ST_MUL;
      ST_MUL:     state_next = ST_OUT;
      ST_OUT:     if (!m_tvalid || m_tready) state_next = ST_COLLECT;
      default:    state_next = ST_COLLECT;
    endcase
  end

  always_comb begin
    rate_raw = 19'sd5 * (19'(hist[0]) - 19'(hist[HistoryLag]));
    if (rate_raw > RateLimit) rate_raw = RateLimit;
    if (rate_raw < -RateLimit) rate_raw = -RateLimit;
    acc = 36'(prod_p) + 36'(prod_d);
    mag = acc < 0 ? -acc : acc;
    mag = mag >>> 14;
    drive = acc < 0 ? -mag : mag;
    if (drive > 36'sd32767) drive = 36'sd32767;
    if (drive < -36'sd32768) drive = -36'sd32768;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
      count <= '0;
      p_gain <= 16'd1000;
      d_gain <= 16'd0;
      m_tvalid <= 1'b0;
      got_l <= 1'b0;
      got_r <= 1'b0;
      for (int i = 0; i < HistDepth; i++) hist[i] <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegPGain: p_gain <= cfg_data;
          RegDGain: d_gain <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        count <= l_ctl.start ? '0 : count + 1'b1;
        neg <= 1'b0;
      end
      if (l_ctl.done) got_l <= 1'b1;
      if (r_ctl.done) got_r <= 1'b1;
      if (state == ST_TRIM) begin
        got_l <= 1'b0;
        got_r <= 1'b0;
        neg <= l_val < r_val;
        zero_sum <= (lsum == '0);
      end
      if (state == ST_DIVIDE && div_done) begin
        err <= zero_sum ? 16'sd0 : (neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot}));
        hist[0] <= zero_sum ? 16'sd0 : (neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot}));
        for (int i = 1; i < HistDepth; i++) hist[i] <= hist[i-1];
      end
      if (state == ST_RATE) begin
        rate <= 15'(rate_raw);
        prod_p <= 34'(err) * $signed({18'd0, p_gain});
        prod_d <= 34'(rate_raw) * $signed({18'd0, d_gain});
      end
      if (state == ST_MUL) begin
        drive_q <= 16'(drive);
      end
      if (state == ST_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
        m_tdata[15:0] <= drive_q;
        m_tdata[31:16] <= err;
        m_tdata[46:32] <= rate;
        m_tdata[47] <= 1'b0;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

[rtl/tmps_checker.sv]
`default_nettype none
module tmps_checker (
  input wire        clk,
  input wire        rst,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [47:0] m_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
  a_err: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[31:16]) <= 16384 && $signed(m_tdata[31:16]) >= -16384))
    else $error("error out of range");
  a_rate: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[46:32]) <= 11469 && $signed(m_tdata[46:32]) >= -11469))
    else $error("rate out of range");
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid) else $error("valid after reset");
endmodule
bind trimmed_mean_pd_steering_unit tmps_checker u_chk (
  .clk(clk), .rst(rst),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
